@@ rtl/bfdt_pkg.sv @@
// shared constants and the constant divide-by-ten helper for the fixed-point to text block
`default_nettype none

package bfdt_pkg;

  // largest in-range input is one below this (1000.00 at 8 fraction bits)
  localparam logic [31:0] LIMIT_VALUE = 32'd256000;

  // largest count of hundredths that fits "ddd.dd"
  localparam logic [16:0] Q_MAX = 17'd99999;

  // scale from 1/256 units to thousandths before the shift
  localparam logic [27:0] SCALE_K = 28'd1000;

  // rounding bias in thousandths
  localparam logic [19:0] ROUND_BIAS = 20'd5;

  // ceil(2^23 / 10): exact quotient for every input below 2^22
  localparam logic [19:0] RECIP10 = 20'hCCCCD;
  localparam int unsigned RECIP10_SHIFT = 23;

  // ascii codes
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_POINT = 8'h2E;

  // quotient by ten through a reciprocal multiply
  function automatic logic [19:0] div10(input logic [19:0] x);
    logic [39:0] prod;
    prod = 40'(x) * 40'(RECIP10);
    return {3'b000, prod[RECIP10_SHIFT +: 17]};
  endfunction

  // remainder once the quotient is known, one compare-free subtract
  function automatic logic [3:0] rem10(input logic [19:0] x, input logic [19:0] quot);
    logic [19:0] diff;
    diff = x - (quot * 20'd10);
    return diff[3:0];
  endfunction

  // decimal digit to its ascii code
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    return CHAR_ZERO | {4'b0000, d};
  endfunction

endpackage

`default_nettype wire

@@ rtl/bfdt_if.sv @@
// word channels of the fixed-point to text block: input value and six-character result
`default_nettype none

interface bfdt_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface bfdt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] hundreds_char;
  logic [7:0] tens_char;
  logic [7:0] ones_char;
  logic [7:0] point_char;
  logic [7:0] tenths_char;
  logic [7:0] hundredths_char;
  logic       overflow;

  modport source (
    output valid, output hundreds_char, output tens_char, output ones_char,
    output point_char, output tenths_char, output hundredths_char, output overflow,
    input ready
  );
  modport sink (
    input valid, input hundreds_char, input tens_char, input ones_char,
    input point_char, input tenths_char, input hundredths_char, input overflow,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/binary_fixed_to_decimal_text.sv @@
// top level: pipelined unsigned 24.8 fixed-point to "ddd.dd" ascii text converter
//
// in_ch carries one 32-bit word: an unsigned value with 8 fraction bits.
// out_ch carries six ascii characters "ddd.dd" (value/256 rounded to
// hundredths, leading zeros of the hundreds and tens places as spaces) and
// an overflow flag. Inputs of 256000 and above give "***.**" with overflow
// set; 255999 rounds up past full scale and is shown as "999.99".
// Both channels use valid/ready; a word moves when both are high.
// Six register stages: scale, round, three divide-by-ten stages that each
// peel one decimal digit, and the output register, which splits off the
// tens and hundreds digits. A word moves through the stages in order and
// shows on out_ch from the output register. Throughput is one word per cycle
// while out_ch.ready is high; every stage holds one word and has its own
// constant multiplier. When the receiver stalls, full stages hold and empty
// stages further up still fill, so in_ch.ready drops only once all six are
// full. Synchronous active-low reset empties the pipeline; payload is not reset.
`default_nettype none

module binary_fixed_to_decimal_text (
  input  wire logic        clk,
  input  wire logic        rst_n,
  bfdt_in_if.sink          in_ch,
  bfdt_out_if.source       out_ch
);

  localparam int unsigned NSTAGE = 6;

  // per-stage valid bits and enables
  logic [NSTAGE:1] vld_r;
  logic [NSTAGE:1] vld_nxt;
  logic [NSTAGE+1:1] en;

  // stage 1: thousandths
  logic [19:0] m1_r;
  logic        ovf1_r;
  // stage 2: count of hundredths
  logic [16:0] q2_r;
  logic        ovf2_r;
  // stage 3: hundredths digit split off
  logic [13:0] a3_r;
  logic [3:0]  hu3_r;
  logic        ovf3_r;
  // stage 4: tenths digit split off
  logic [9:0]  b4_r;
  logic [3:0]  te4_r;
  logic [3:0]  hu4_r;
  logic        ovf4_r;
  // stage 5: ones digit split off
  logic [6:0]  c5_r;
  logic [3:0]  o5_r;
  logic [3:0]  te5_r;
  logic [3:0]  hu5_r;
  logic        ovf5_r;
  // stage 6: output characters
  logic [7:0]  hch_r, tch_r, och_r, tech_r, huch_r;
  logic        ovf6_r;

  // a stage advances when it is empty or the next one advances
  always_comb begin
    en[NSTAGE+1] = out_ch.ready;
    for (int k = NSTAGE; k >= 1; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_ch.ready = en[1];

  // valid bits follow the data
  always_comb begin
    vld_nxt = vld_r;
    if (en[1]) begin
      vld_nxt[1] = in_ch.valid;
    end
    for (int k = 2; k <= NSTAGE; k++) begin
      if (en[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // stage 1 logic: range check and value * 1000 / 256
  logic [27:0] prod1;
  logic        ovf_in;
  assign prod1  = 28'(in_ch.value[17:0]) * bfdt_pkg::SCALE_K;
  assign ovf_in = (in_ch.value >= bfdt_pkg::LIMIT_VALUE);

  // stage 2 logic: round to hundredths and saturate
  logic [19:0] q_full;
  logic [16:0] q_sat;
  assign q_full = bfdt_pkg::div10(m1_r + bfdt_pkg::ROUND_BIAS);
  assign q_sat  = (q_full > 20'(bfdt_pkg::Q_MAX)) ? bfdt_pkg::Q_MAX : q_full[16:0];

  // stage 3..5 logic: one decimal digit per stage; h_quot feeds stage 6
  logic [19:0] a_quot, b_quot, c_quot, h_quot;
  assign a_quot = bfdt_pkg::div10(20'(q2_r));
  assign b_quot = bfdt_pkg::div10(20'(a3_r));
  assign c_quot = bfdt_pkg::div10(20'(b4_r));
  assign h_quot = bfdt_pkg::div10(20'(c5_r));

  // stage 6 logic: digit split of the top two places and blanking
  logic [3:0] h_dig, t_dig;
  assign h_dig = h_quot[3:0];
  assign t_dig = bfdt_pkg::rem10(20'(c5_r), h_quot);

  // payload registers
  always_ff @(posedge clk) begin
    if (en[1]) begin
      m1_r   <= prod1[27:8];
      ovf1_r <= ovf_in;
    end
    if (en[2]) begin
      q2_r   <= q_sat;
      ovf2_r <= ovf1_r;
    end
    if (en[3]) begin
      a3_r   <= a_quot[13:0];
      hu3_r  <= bfdt_pkg::rem10(20'(q2_r), a_quot);
      ovf3_r <= ovf2_r;
    end
    if (en[4]) begin
      b4_r   <= b_quot[9:0];
      te4_r  <= bfdt_pkg::rem10(20'(a3_r), b_quot);
      hu4_r  <= hu3_r;
      ovf4_r <= ovf3_r;
    end
    if (en[5]) begin
      c5_r   <= c_quot[6:0];
      o5_r   <= bfdt_pkg::rem10(20'(b4_r), c_quot);
      te5_r  <= te4_r;
      hu5_r  <= hu4_r;
      ovf5_r <= ovf4_r;
    end
    if (en[6]) begin
      if (ovf5_r) begin
        hch_r  <= bfdt_pkg::CHAR_STAR;
        tch_r  <= bfdt_pkg::CHAR_STAR;
        och_r  <= bfdt_pkg::CHAR_STAR;
        tech_r <= bfdt_pkg::CHAR_STAR;
        huch_r <= bfdt_pkg::CHAR_STAR;
      end else begin
        hch_r  <= (h_dig == 4'd0) ? bfdt_pkg::CHAR_SPACE : bfdt_pkg::digit_char(h_dig);
        tch_r  <= (h_dig == 4'd0 && t_dig == 4'd0) ? bfdt_pkg::CHAR_SPACE
                                                   : bfdt_pkg::digit_char(t_dig);
        och_r  <= bfdt_pkg::digit_char(o5_r);
        tech_r <= bfdt_pkg::digit_char(te5_r);
        huch_r <= bfdt_pkg::digit_char(hu5_r);
      end
      ovf6_r <= ovf5_r;
    end
  end

  // result word
  assign out_ch.valid           = vld_r[NSTAGE];
  assign out_ch.hundreds_char   = hch_r;
  assign out_ch.tens_char       = tch_r;
  assign out_ch.ones_char       = och_r;
  assign out_ch.point_char      = bfdt_pkg::CHAR_POINT;
  assign out_ch.tenths_char     = tech_r;
  assign out_ch.hundredths_char = huch_r;
  assign out_ch.overflow        = ovf6_r;

endmodule

`default_nettype wire

@@ tb/sv/binary_fixed_to_decimal_text_tb.sv @@
// testbench for the fixed-point to "ddd.dd" text converter: table, random words, self-check
module binary_fixed_to_decimal_text_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int          RANDOM_PHASES = 4;
  localparam int          WORDS_PER_PHASE = 150;
  localparam int          LONG_HOLD = 80;
  localparam int          TAIL_CYCLES = 20;
  localparam int          PRINT_CAP = 40;

  // six characters then the overflow flag, in port order
  typedef struct packed {
    logic [7:0] hundreds;
    logic [7:0] tens;
    logic [7:0] ones;
    logic [7:0] point;
    logic [7:0] tenths;
    logic [7:0] hundredths;
    logic       overflow;
  } text_word_t;

  typedef struct {
    logic [31:0] value;
    text_word_t  text;
  } pending_text_t;

  typedef struct packed {
    logic [31:0] value;
    logic        typed;
    text_word_t  want;
  } dir_row_t;

  // directed words; typed rows carry the text by hand, others use the predictor
  localparam dir_row_t DIR_ROWS [21] = '{
    '{32'd0,          1'b1, {"  0.00", 1'b0}},
    '{32'd1,          1'b0, '0},
    '{32'd2,          1'b0, '0},
    '{32'd128,        1'b1, {"  0.50", 1'b0}},
    '{32'd255,        1'b0, '0},
    '{32'd256,        1'b1, {"  1.00", 1'b0}},
    '{32'd2559,       1'b0, '0},
    '{32'd2560,       1'b1, {" 10.00", 1'b0}},
    '{32'd25599,      1'b0, '0},
    '{32'd25600,      1'b1, {"100.00", 1'b0}},
    '{32'd65535,      1'b0, '0},
    '{32'd255998,     1'b0, '0},
    '{32'd255999,     1'b1, {"999.99", 1'b0}},
    '{32'd256000,     1'b1, {"***.**", 1'b1}},
    '{32'd256001,     1'b0, '0},
    '{32'h00FF_FFFF,  1'b0, '0},
    '{32'h5555_5555,  1'b0, '0},
    '{32'hAAAA_AAAA,  1'b0, '0},
    '{32'h7FFF_FFFF,  1'b0, '0},
    '{32'h8000_0000,  1'b0, '0},
    '{32'hFFFF_FFFF,  1'b1, {"***.**", 1'b1}}
  };

  string char_name [6] = '{"hundreds_char", "tens_char", "ones_char",
                           "point_char", "tenths_char", "hundredths_char"};

  logic clk;
  logic rst_n;

  bfdt_in_if  in_ch ();
  bfdt_out_if out_ch ();

  binary_fixed_to_decimal_text u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pending_text_t text_q [$];
  int unsigned   cycle_count = 0;
  int            mismatch_count = 0;
  int            words_sent = 0;
  int            results_checked = 0;
  int            overflow_seen = 0;
  int            full_scale_seen = 0;
  bit            src_idle_on = 1'b1;
  bit            snk_idle_on = 1'b1;
  bit            long_hold_req = 1'b0;

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // expected text for one fixed-point word
  function automatic text_word_t format_fixed(input logic [31:0] v);
    text_word_t  t;
    logic [63:0] thousandths;
    logic [31:0] cents;
    logic [3:0]  hund, ten, one, tenth, hundredth;
    t.point = bfdt_pkg::CHAR_POINT;
    if (v >= bfdt_pkg::LIMIT_VALUE) begin
      t.hundreds   = bfdt_pkg::CHAR_STAR;
      t.tens       = bfdt_pkg::CHAR_STAR;
      t.ones       = bfdt_pkg::CHAR_STAR;
      t.tenths     = bfdt_pkg::CHAR_STAR;
      t.hundredths = bfdt_pkg::CHAR_STAR;
      t.overflow   = 1'b1;
      return t;
    end
    // scale to thousandths, round half up into hundredths, clamp at 999.99
    thousandths = (64'(v) * 64'd1000) >> 8;
    cents = 32'((thousandths + 64'd5) / 64'd10);
    if (cents > 32'd99999) cents = 32'd99999;
    hund      = 4'(cents / 10000);
    ten       = 4'((cents / 1000) % 10);
    one       = 4'((cents / 100) % 10);
    tenth     = 4'((cents / 10) % 10);
    hundredth = 4'(cents % 10);
    t.hundreds   = (hund == 0) ? bfdt_pkg::CHAR_SPACE : bfdt_pkg::CHAR_ZERO + 8'(hund);
    t.tens       = (hund == 0 && ten == 0) ? bfdt_pkg::CHAR_SPACE
                                           : bfdt_pkg::CHAR_ZERO + 8'(ten);
    t.ones       = bfdt_pkg::CHAR_ZERO + 8'(one);
    t.tenths     = bfdt_pkg::CHAR_ZERO + 8'(tenth);
    t.hundredths = bfdt_pkg::CHAR_ZERO + 8'(hundredth);
    t.overflow   = 1'b0;
    return t;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] value,
                                 input logic [7:0] got, input logic [7:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("mismatch %s: value=%0d got=%h want=%h at cycle %0d",
               what, value, got, want, cycle_count);
    mismatch_count++;
  endtask

  // offer one word, after a random gap when source idling is on, record its text once accepted
  task automatic send_word(input logic [31:0] v, input logic typed, input text_word_t hand_text);
    int gap;
    gap = src_idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    text_q.push_back('{value: v, text: typed ? hand_text : format_fixed(v)});
    words_sent++;
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (text_q.size() != 0) @(posedge clk);
  endtask

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, text_q.size());
      $display("FAIL binary_fixed_to_decimal_text");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold on request
  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold_req) begin
        stall = LONG_HOLD;
        long_hold_req = 1'b0;
      end else begin
        stall = snk_idle_on ? $urandom_range(0, 10) : 0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // compare each accepted result word with the oldest expected text
  always @(posedge clk) begin
    text_word_t    got;
    pending_text_t exp_text;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.hundreds_char, out_ch.tens_char, out_ch.ones_char, out_ch.point_char,
             out_ch.tenths_char, out_ch.hundredths_char, out_ch.overflow};
      if (text_q.size() == 0) begin
        report_mismatch("unexpected result word", 32'd0, got[48:41], 8'h00);
      end else begin
        exp_text = text_q.pop_front();
        for (int i = 0; i < 6; i++)
          if (got[48 - 8*i -: 8] !== exp_text.text[48 - 8*i -: 8])
            report_mismatch(char_name[i], exp_text.value, got[48 - 8*i -: 8],
                            exp_text.text[48 - 8*i -: 8]);
        if (got.overflow !== exp_text.text.overflow)
          report_mismatch("overflow", exp_text.value, 8'(got.overflow),
                          8'(exp_text.text.overflow));
        results_checked++;
        if (exp_text.text.overflow) overflow_seen++;
        if (exp_text.text == {"999.99", 1'b0}) full_scale_seen++;
      end
    end
  end

  // reset, directed table, random phases, end of run
  initial begin : stimulus
    logic [31:0] v;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_ROWS[i])
      send_word(DIR_ROWS[i].value, DIR_ROWS[i].typed, DIR_ROWS[i].want);
    drain_results();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      // phase 1 runs flat out on both sides, phase 2 starts with a long result hold
      src_idle_on = (phase != 1) && (phase != 2);
      snk_idle_on = (phase != 1);
      if (phase == 2) long_hold_req = 1'b1;
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        if (phase == 2 && k == 60) src_idle_on = 1'b1;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: v = $urandom_range(0, 255999);
          6:                v = $urandom_range(255900, 256100);
          7:                v = $urandom_range(0, 26000);
          default:          v = $urandom();
        endcase
        send_word(v, 1'b0, '0);
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d words, %0d results checked: %0d overflow, %0d at 999.99",
             words_sent, results_checked, overflow_seen, full_scale_seen);
    $display("long result hold, back-to-back streaming and random gaps; %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0 && text_q.size() == 0) begin
      $display("PASS binary_fixed_to_decimal_text");
    end else begin
      $display("FAIL binary_fixed_to_decimal_text");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/bfdt_pkg.sv
rtl/bfdt_if.sv
rtl/binary_fixed_to_decimal_text.sv
tb/sv/binary_fixed_to_decimal_text_tb.sv
